[hdl/assert_macros.svh]
// Assertion macros for the sonar echo range timer RTL.
// Included by every module that carries concurrent assertions; no dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SERTU_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("sertu assertion failed");
`define SERTU_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sertu assertion failed");
`define SERTU_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sertu assertion failed");
`else
`define SERTU_ASSERT(label, clk, rst, prop)
`define SERTU_ASSERT_IMP(label, clk, rst, ante, cons)
`define SERTU_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

[hdl/sertu_pkg.sv]
// Types and constants for the sonar echo range timer.
// Used by sonar_echo_range_timer_unit; no dependencies.
package sertu_pkg;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 17;
   localparam int PRE_LOW_W  = 10;
   localparam int HIGH_W     = 10;
   localparam int ARM_W      = 16;
   localparam int TIMEOUT_W  = 17;
   localparam int RANGE_W    = 16;
   localparam int FACTOR_W   = 16;
   localparam int COUNT_W    = 17;
   localparam int DIST_W     = 16;
   localparam int CLOSEST_W  = 20;
   localparam int STATUS_W   = 2;
   localparam int PROD_W     = COUNT_W + FACTOR_W;
   localparam int FRAC_W     = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_PRE_LOW      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TRIGGER_HIGH = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ARM_DELAY    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_EDGE_TIMEOUT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_RANGE    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_MM_FACTOR    = 3'd5;

   localparam logic [PRE_LOW_W-1:0] PRE_LOW_RESET      = 10'd10;
   localparam logic [HIGH_W-1:0]    TRIGGER_HIGH_RESET = 10'd5;
   localparam logic [ARM_W-1:0]     ARM_DELAY_RESET    = 16'd500;
   localparam logic [TIMEOUT_W-1:0] EDGE_TIMEOUT_RESET = 17'd100000;
   localparam logic [RANGE_W-1:0]   MAX_RANGE_RESET    = 16'd3000;
   localparam logic [FACTOR_W-1:0]  MM_FACTOR_RESET    = 16'd11151;
   localparam logic [CLOSEST_W-1:0] CLOSEST_RESET      = 20'd999000;

   localparam logic [STATUS_W-1:0] ST_VALID      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NO_RISE    = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NO_FALL    = 2'd2;
   localparam logic [STATUS_W-1:0] ST_OUT_RANGE  = 2'd3;

   localparam int OUT_DEPTH = 3;
   localparam int PTR_W     = 2;
   localparam int OCC_W     = 3;

   typedef enum logic [2:0] {
      PH_IDLE   = 3'd0,
      PH_PRELOW = 3'd1,
      PH_HIGH   = 3'd2,
      PH_ARM    = 3'd3,
      PH_RISE   = 3'd4,
      PH_FALL   = 3'd5
   } phase_type;

   typedef struct packed {
      logic                 trigger_level;
      logic                 done_res;
      logic [STATUS_W-1:0]  status;
      logic [DIST_W-1:0]    distance_mm;
      logic [CLOSEST_W-1:0] closest_mm;
      logic [DIST_W-1:0]    farthest_mm;
   } rsp_type;

endpackage

[hdl/sonar_echo_range_timer_unit.sv]
// Sonar echo range timer: trigger sequencing, echo pulse timing and distance scaling.
// Depends on sertu_pkg and assert_macros.svh.
// Each accepted word is one 1 us tick and yields exactly one response word. The block
// takes one word per clock while req_ready is high; a request is held in the input
// register, and its result enters the three-entry queue behind the single-pass tick logic.
// Request ready drops only when the response queue and the input register together hold
// three words. Distance is the echo width times the Q16 factor, truncated, from one
// 17x16 multiply in the tick logic.
`include "assert_macros.svh"

module sonar_echo_range_timer_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_cmd,
   input  logic                            req_echo_level,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_trigger_level,
   output logic                            rsp_done_res,
   output logic [sertu_pkg::STATUS_W-1:0]  rsp_status,
   output logic [sertu_pkg::DIST_W-1:0]    rsp_distance_mm,
   output logic [sertu_pkg::CLOSEST_W-1:0] rsp_closest_mm,
   output logic [sertu_pkg::DIST_W-1:0]    rsp_farthest_mm,
   input  logic                            csr_wr_en,
   input  logic [sertu_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [sertu_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import sertu_pkg::*;

   logic [PRE_LOW_W-1:0] pre_low_ff;
   logic [HIGH_W-1:0]    trig_high_ff;
   logic [ARM_W-1:0]     arm_delay_ff;
   logic [TIMEOUT_W-1:0] timeout_ff;
   logic [RANGE_W-1:0]   max_range_ff;
   logic [FACTOR_W-1:0]  factor_ff;

   logic s1_valid_ff, s1_cmd_ff, s1_echo_ff;

   phase_type            phase_ff, phase_in, phase_eff;
   logic [COUNT_W-1:0]   count_ff, count_in, count_eff;
   logic [COUNT_W-1:0]   width_ff, width_in;
   logic                 prev_echo_ff;
   logic [CLOSEST_W-1:0] closest_ff, closest_in;
   logic [DIST_W-1:0]    farthest_ff, farthest_in;

   logic                 rise, fall;
   logic [COUNT_W:0]     rise_count;
   logic [COUNT_W-1:0]   fall_count, fall_width;
   logic [PROD_W-1:0]    product;
   logic [COUNT_W-1:0]   dist_raw;
   logic                 dist_ok;
   rsp_type              result;

   rsp_type              queue_ff [OUT_DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, rd_ptr_ff;
   logic [PTR_W-1:0]     occ_ff;
   logic                 push, pop;
   logic [OCC_W-1:0]     in_flight;

   always_ff @(posedge clock) begin
      if (reset) begin
         pre_low_ff   <= PRE_LOW_RESET;
         trig_high_ff <= TRIGGER_HIGH_RESET;
         arm_delay_ff <= ARM_DELAY_RESET;
         timeout_ff   <= EDGE_TIMEOUT_RESET;
         max_range_ff <= MAX_RANGE_RESET;
         factor_ff    <= MM_FACTOR_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_PRE_LOW:      pre_low_ff   <= csr_wdata[PRE_LOW_W-1:0];
            CSR_TRIGGER_HIGH: trig_high_ff <= csr_wdata[HIGH_W-1:0];
            CSR_ARM_DELAY:    arm_delay_ff <= csr_wdata[ARM_W-1:0];
            CSR_EDGE_TIMEOUT: timeout_ff   <= csr_wdata[TIMEOUT_W-1:0];
            CSR_MAX_RANGE:    max_range_ff <= csr_wdata[RANGE_W-1:0];
            CSR_MM_FACTOR:    factor_ff    <= csr_wdata[FACTOR_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Input register; the credit check keeps queue plus this stage within the queue depth.
   assign in_flight = OCC_W'(occ_ff) + OCC_W'(s1_valid_ff);
   assign req_ready = (in_flight < OCC_W'(OUT_DEPTH));

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= req_valid && req_ready;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_cmd_ff  <= req_cmd;
         s1_echo_ff <= req_echo_level;
      end
   end

   assign rise = s1_echo_ff && !prev_echo_ff;
   assign fall = !s1_echo_ff && prev_echo_ff;

   // A start lands in the pre-low phase; phases of zero length fall through in the same tick.
   always_comb begin
      phase_eff = phase_ff;
      count_eff = count_ff;
      if (phase_ff == PH_IDLE && s1_cmd_ff) begin
         phase_eff = PH_PRELOW;
         count_eff = '0;
      end
      if (phase_eff == PH_PRELOW && count_eff >= COUNT_W'(pre_low_ff)) begin
         phase_eff = PH_HIGH;
         count_eff = '0;
      end
      if (phase_eff == PH_HIGH && count_eff >= COUNT_W'(trig_high_ff)) begin
         phase_eff = PH_ARM;
         count_eff = '0;
      end
      if (phase_eff == PH_ARM && count_eff >= COUNT_W'(arm_delay_ff)) begin
         phase_eff = PH_RISE;
         count_eff = '0;
      end
   end

   assign rise_count = {1'b0, count_eff} + 1'b1;
   assign fall_count = count_eff + 1'b1;
   assign fall_width = width_ff + 1'b1;
   assign product    = PROD_W'(fall_width) * PROD_W'(factor_ff);
   assign dist_raw   = product[PROD_W-1:FRAC_W];
   assign dist_ok    = (dist_raw != '0) && (dist_raw < COUNT_W'(max_range_ff));

   always_comb begin
      phase_in = phase_eff;
      count_in = count_eff;
      width_in = width_ff;
      unique case (phase_eff)
         PH_PRELOW, PH_HIGH, PH_ARM: begin
            count_in = fall_count;
         end
         PH_RISE: begin
            if (rise) begin
               phase_in = PH_FALL;
               count_in = '0;
               width_in = '0;
            end else if (rise_count >= {1'b0, timeout_ff}) begin
               phase_in = PH_IDLE;
               count_in = '0;
            end else begin
               count_in = rise_count[COUNT_W-1:0];
            end
         end
         PH_FALL: begin
            width_in = fall_width;
            count_in = fall_count;
            if (fall || fall_count >= timeout_ff) begin
               phase_in = PH_IDLE;
               count_in = '0;
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   always_comb begin
      result.trigger_level = (phase_eff == PH_HIGH);
      result.done_res      = 1'b0;
      result.status        = ST_VALID;
      result.distance_mm   = '0;
      closest_in           = closest_ff;
      farthest_in          = farthest_ff;
      unique case (phase_eff)
         PH_RISE: begin
            if (!rise && rise_count >= {1'b0, timeout_ff}) begin
               result.done_res = 1'b1;
               result.status   = ST_NO_RISE;
            end
         end
         PH_FALL: begin
            if (fall) begin
               result.done_res = 1'b1;
               if (dist_ok) begin
                  result.distance_mm = dist_raw[DIST_W-1:0];
                  if (CLOSEST_W'(dist_raw[DIST_W-1:0]) < closest_ff) begin
                     closest_in = CLOSEST_W'(dist_raw[DIST_W-1:0]);
                  end
                  if (dist_raw[DIST_W-1:0] > farthest_ff) begin
                     farthest_in = dist_raw[DIST_W-1:0];
                  end
               end else begin
                  result.status = ST_OUT_RANGE;
               end
            end else if (fall_count >= timeout_ff) begin
               result.done_res = 1'b1;
               result.status   = ST_NO_FALL;
            end
         end
         default: begin
         end
      endcase
      result.closest_mm  = closest_in;
      result.farthest_mm = farthest_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         count_ff     <= '0;
         width_ff     <= '0;
         prev_echo_ff <= 1'b0;
         closest_ff   <= CLOSEST_RESET;
         farthest_ff  <= '0;
      end else if (s1_valid_ff) begin
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         width_ff     <= width_in;
         prev_echo_ff <= s1_echo_ff;
         closest_ff   <= closest_in;
         farthest_ff  <= farthest_in;
      end
   end

   assign push = s1_valid_ff;
   assign pop  = rsp_valid && rsp_ready;

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         occ_ff    <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(OUT_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(OUT_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         occ_ff <= occ_ff + PTR_W'(push) - PTR_W'(pop);
      end
   end

   assign rsp_valid         = (occ_ff != '0);
   assign rsp_trigger_level = queue_ff[rd_ptr_ff].trigger_level;
   assign rsp_done_res      = queue_ff[rd_ptr_ff].done_res;
   assign rsp_status        = queue_ff[rd_ptr_ff].status;
   assign rsp_distance_mm   = queue_ff[rd_ptr_ff].distance_mm;
   assign rsp_closest_mm    = queue_ff[rd_ptr_ff].closest_mm;
   assign rsp_farthest_mm   = queue_ff[rd_ptr_ff].farthest_mm;

   `SERTU_ASSERT(a_credit_bound, clock, reset, in_flight <= OCC_W'(OUT_DEPTH))
   `SERTU_ASSERT_NXT(a_done_goes_idle, clock, reset, s1_valid_ff && result.done_res, phase_ff == PH_IDLE)
   `SERTU_ASSERT_NXT(a_closest_monotone, clock, reset, 1'b1, closest_ff <= $past(closest_ff))
   `SERTU_ASSERT_NXT(a_farthest_monotone, clock, reset, 1'b1, farthest_ff >= $past(farthest_ff))
   `SERTU_ASSERT_IMP(a_idle_result_clear, clock, reset, rsp_valid && !rsp_done_res, rsp_status == ST_VALID && rsp_distance_mm == '0)

endmodule
